FILE: rtl/assert_macros.svh
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HNW_ASSERT_NOW(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("hnw assertion failed");
`define HNW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hnw assertion failed");
`else
`define HNW_ASSERT_NOW(lbl, clk, rst_n, expr)
`define HNW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/hnw_pkg.sv
// types, constants and tables of the neighbour weight engine
// no dependencies
`default_nettype none
package hnw_pkg;
    localparam int SIDE_W       = 8;
    localparam int MAX_SIDE     = 256;
    localparam int ADDR_W       = 2 * SIDE_W;
    localparam int STORE_DEPTH  = 1 << ADDR_W;
    localparam int PIX_W        = 48;
    localparam int SUM_W        = 18;
    localparam int DEF_RADIUS   = 3;
    localparam int DEF_CHANNELS = 3;
    localparam int DIV_STEPS    = 33;
    localparam int DIV_CNT_W    = 6;
    localparam int OFF_W        = 5;
    localparam int POS_W        = 10;

    typedef enum logic [2:0] {
        CFG_STRIDE   = 3'd0,
        CFG_CHANNELS = 3'd1,
        CFG_LOW      = 3'd2,
        CFG_HIGH     = 3'd3,
        CFG_FLAT     = 3'd4,
        CFG_FLOOR    = 3'd5,
        CFG_ROWS     = 3'd6,
        CFG_COLS     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        func;
        logic [7:0]  pixel_row;
        logic [7:0]  pixel_col;
        logic [15:0] smooth_ch0;
        logic [15:0] smooth_ch1;
        logic [15:0] smooth_ch2;
        logic [15:0] ref_ch0;
        logic [15:0] ref_ch1;
        logic [15:0] ref_ch2;
    } t_in;

    typedef struct packed {
        logic [15:0] neighbour_index;
        logic [31:0] weight;
        logic        last_of_window;
        logic        window_empty;
    } t_out;

    // effective settings after saturation
    typedef struct packed {
        logic [1:0]       stride;
        logic [1:0]       chans;
        logic [SUM_W-1:0] low;
        logic [SUM_W-1:0] high;
        logic [31:0]      flat;
        logic [31:0]      floor_w;
        logic [8:0]       rows;
        logic [8:0]       cols;
    } t_cfg;

    typedef struct packed {
        logic        wr_en;
        logic        rd_en;
        logic [7:0]  cen_row;
        logic [7:0]  cen_col;
        logic [7:0]  nb_row;
        logic [7:0]  nb_col;
        logic [1:0]  abs_s;
        logic [1:0]  abs_t;
        logic        sum_en;
        logic        wgt_en;
        logic        mul_en;
        logic        emit_en;
        logic        emit_last;
        logic        emit_empty;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic out_free;
    } t_sts;

    function automatic logic [32:0] f_dividend(input logic [1:0] n);
        logic [32:0] d;
        case (n)
            2'd2:    d = 33'd4261478400;
            2'd3:    d = 33'd6392217600;
            default: d = 33'd2130739200;
        endcase
        return d;
    endfunction

    // q0.16 normalized gaussian, sigma equal to radius
    function automatic logic [15:0] f_gauss(input logic [1:0] rad, input logic [1:0] as,
                                            input logic [1:0] at);
        logic [15:0] g;
        case ({rad, as, at})
            6'b01_00_00: g = 16'd13381;
            6'b01_00_01: g = 16'd8116;
            6'b01_01_00: g = 16'd8116;
            6'b01_01_01: g = 16'd4923;
            6'b10_00_00: g = 16'd4141;
            6'b10_00_01: g = 16'd3655;
            6'b10_00_10: g = 16'd2512;
            6'b10_01_00: g = 16'd3655;
            6'b10_01_01: g = 16'd3225;
            6'b10_01_10: g = 16'd2217;
            6'b10_10_00: g = 16'd2512;
            6'b10_10_01: g = 16'd2217;
            6'b10_10_10: g = 16'd1524;
            6'b11_00_00: g = 16'd2013;
            6'b11_00_01: g = 16'd1904;
            6'b11_00_10: g = 16'd1612;
            6'b11_00_11: g = 16'd1221;
            6'b11_01_00: g = 16'd1904;
            6'b11_01_01: g = 16'd1801;
            6'b11_01_10: g = 16'd1524;
            6'b11_01_11: g = 16'd1155;
            6'b11_10_00: g = 16'd1612;
            6'b11_10_01: g = 16'd1524;
            6'b11_10_10: g = 16'd1290;
            6'b11_10_11: g = 16'd977;
            6'b11_11_00: g = 16'd1221;
            6'b11_11_01: g = 16'd1155;
            6'b11_11_10: g = 16'd977;
            6'b11_11_11: g = 16'd740;
            default:     g = 16'd0;
        endcase
        return g;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/hnw_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module hnw_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/hnw_ctrl.sv
// controller: request intake and neighbour window walk
// depends on hnw_pkg
`default_nettype none
module hnw_ctrl import hnw_pkg::*; #(
    parameter int RADIUS = DEF_RADIUS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_in  i_in_data,
    input  wire t_cfg i_cfg,
    input  wire t_sts i_sts,
    output logic      o_in_stall,
    output t_cmd      o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SCAN = 8'b0000_0010,
        S_READ = 8'b0000_0100,
        S_SUM  = 8'b0000_1000,
        S_WGT  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_MUL  = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    localparam logic signed [OFF_W-1:0] R_POS = OFF_W'(RADIUS);
    localparam logic signed [OFF_W-1:0] R_NEG = -R_POS;

    t_state                   r_state, n_state;
    logic [7:0]               r_row, n_row, r_col, n_col;
    logic signed [OFF_W-1:0]  r_t, n_t, r_s, n_s;
    logic                     r_pending, n_pending, r_final, n_final, r_empty, n_empty;

    logic signed [POS_W-1:0]  w_nr, w_nc;
    logic signed [OFF_W-1:0]  w_str, w_s_nx, w_t_nx, w_as, w_at;
    logic                     w_pos_ok, w_s_wrap, w_t_wrap, w_over, w_in_img;

    assign w_nr  = $signed({2'b00, r_row}) + POS_W'(r_s);
    assign w_nc  = $signed({2'b00, r_col}) + POS_W'(r_t);
    assign w_pos_ok = !w_nr[POS_W-1] && (w_nr < $signed({1'b0, i_cfg.rows}))
                   && !w_nc[POS_W-1] && (w_nc < $signed({1'b0, i_cfg.cols}))
                   && !(r_s == '0 && r_t == '0);
    assign w_str    = $signed({3'b000, i_cfg.stride});
    assign w_s_nx   = r_s + w_str;
    assign w_t_nx   = r_t + w_str;
    assign w_s_wrap = w_s_nx > R_POS;
    assign w_t_wrap = w_t_nx > R_POS;
    assign w_over   = w_s_wrap && w_t_wrap;
    assign w_as     = r_s[OFF_W-1] ? -r_s : r_s;
    assign w_at     = r_t[OFF_W-1] ? -r_t : r_t;
    assign w_in_img = ({1'b0, i_in_data.pixel_row} < i_cfg.rows)
                   && ({1'b0, i_in_data.pixel_col} < i_cfg.cols);

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_t       = r_t;
        n_s       = r_s;
        n_pending = r_pending;
        n_final   = r_final;
        n_empty   = r_empty;
        o_cmd            = '0;
        o_cmd.cen_row    = r_row;
        o_cmd.cen_col    = r_col;
        o_cmd.nb_row     = w_nr[7:0];
        o_cmd.nb_col     = w_nc[7:0];
        o_cmd.abs_s      = w_as[1:0];
        o_cmd.abs_t      = w_at[1:0];
        o_cmd.emit_last  = r_final || r_empty;
        o_cmd.emit_empty = r_empty;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_in_data.func) begin
                        o_cmd.wr_en = w_in_img;
                    end else if (w_in_img) begin
                        n_row     = i_in_data.pixel_row;
                        n_col     = i_in_data.pixel_col;
                        n_t       = R_NEG;
                        n_s       = R_NEG;
                        n_pending = 1'b0;
                        n_final   = 1'b0;
                        n_empty   = 1'b0;
                        n_state   = S_SCAN;
                    end else begin
                        n_empty = 1'b1;
                        n_state = S_EMIT;
                    end
                end
            end
            S_SCAN: begin
                if (w_pos_ok) begin
                    if (r_pending) begin
                        n_final = 1'b0;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_READ;
                    end
                end else if (w_over) begin
                    if (r_pending) begin
                        n_final = 1'b1;
                    end else begin
                        n_empty = 1'b1;
                    end
                    n_state = S_EMIT;
                end else begin
                    n_s = w_s_wrap ? R_NEG : w_s_nx;
                    n_t = w_s_wrap ? w_t_nx : r_t;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = S_WGT;
            end
            S_WGT: begin
                o_cmd.wgt_en = 1'b1;
                n_state      = i_sts.need_div ? S_DIV : S_MUL;
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_pending    = 1'b1;
                if (w_over) begin
                    n_final = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_s     = w_s_wrap ? R_NEG : w_s_nx;
                    n_t     = w_s_wrap ? w_t_nx : r_t;
                    n_state = S_SCAN;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_en = 1'b1;
                    n_pending     = 1'b0;
                    if (r_final || r_empty) begin
                        n_final = 1'b0;
                        n_empty = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pending <= 1'b0;
            r_final   <= 1'b0;
            r_empty   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_final   <= n_final;
            r_empty   <= n_empty;
        end
        r_row <= n_row;
        r_col <= n_col;
        r_t   <= n_t;
        r_s   <= n_s;
    end
endmodule
`default_nettype wire

FILE: rtl/hnw_dp.sv
// datapath: pixel stores, difference sum, divider, spatial product, result register
// depends on hnw_pkg and hnw_ram
`default_nettype none
module hnw_dp import hnw_pkg::*; #(
    parameter int RADIUS = DEF_RADIUS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_in_data,
    input  wire t_cfg i_cfg,
    input  wire t_cmd i_cmd,
    input  wire logic i_out_stall,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out      o_out_data
);
    localparam logic [1:0] RAD = 2'(RADIUS);

    logic [PIX_W-1:0]     w_smooth, w_ref;
    logic [15:0]          w_d0, w_d1, w_d2;
    logic [SUM_W-1:0]     w_sum;
    logic [16:0]          w_idx;
    logic                 w_le_low, w_gt_high;
    logic [SUM_W:0]       w_rem_sh;
    logic                 w_ge;
    logic [31:0]          w_wsel;

    logic [SUM_W-1:0]     r_sum;
    logic [15:0]          r_idx;
    logic [15:0]          r_g;
    logic [31:0]          r_rw;
    logic                 r_use_div;
    logic [32:0]          r_quo;
    logic [SUM_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [47:0]          r_prod;
    logic                 r_out_valid;
    t_out                 r_out;

    hnw_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_smooth_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr ({i_in_data.pixel_col, i_in_data.pixel_row}),
        .i_wdata ({i_in_data.smooth_ch2, i_in_data.smooth_ch1, i_in_data.smooth_ch0}),
        .i_re    (i_cmd.rd_en),
        .i_raddr ({i_cmd.cen_col, i_cmd.cen_row}),
        .o_rdata (w_smooth)
    );

    hnw_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr ({i_in_data.pixel_col, i_in_data.pixel_row}),
        .i_wdata ({i_in_data.ref_ch2, i_in_data.ref_ch1, i_in_data.ref_ch0}),
        .i_re    (i_cmd.rd_en),
        .i_raddr ({i_cmd.nb_col, i_cmd.nb_row}),
        .o_rdata (w_ref)
    );

    assign w_d0 = (w_smooth[15:0] >= w_ref[15:0]) ? w_smooth[15:0] - w_ref[15:0]
                                                  : w_ref[15:0] - w_smooth[15:0];
    assign w_d1 = (w_smooth[31:16] >= w_ref[31:16]) ? w_smooth[31:16] - w_ref[31:16]
                                                    : w_ref[31:16] - w_smooth[31:16];
    assign w_d2 = (w_smooth[47:32] >= w_ref[47:32]) ? w_smooth[47:32] - w_ref[47:32]
                                                    : w_ref[47:32] - w_smooth[47:32];
    assign w_sum = SUM_W'(w_d0)
                 + ((i_cfg.chans >= 2'd2) ? SUM_W'(w_d1) : '0)
                 + ((i_cfg.chans >= 2'd3) ? SUM_W'(w_d2) : '0);

    assign w_idx = 17'(i_cmd.nb_col) * 17'(i_cfg.rows) + 17'(i_cmd.nb_row);

    assign w_le_low  = r_sum <= i_cfg.low;
    assign w_gt_high = r_sum > i_cfg.high;

    assign w_rem_sh = {r_rem, r_quo[32]};
    assign w_ge     = w_rem_sh >= {1'b0, r_sum};

    assign w_wsel = r_use_div ? (r_quo[32] ? 32'hFFFF_FFFF : r_quo[31:0]) : r_rw;

    assign o_sts.need_div = !w_le_low && !w_gt_high;
    assign o_sts.div_busy = (r_cnt != '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_idx <= w_idx[15:0];
            r_g   <= f_gauss(RAD, i_cmd.abs_s, i_cmd.abs_t);
        end
        if (i_cmd.sum_en) begin
            r_sum <= w_sum;
        end
        if (i_cmd.wgt_en) begin
            r_use_div <= o_sts.need_div;
            r_rw      <= w_le_low ? i_cfg.flat : i_cfg.floor_w;
            r_quo     <= f_dividend(i_cfg.chans);
            r_rem     <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? SUM_W'(w_rem_sh - {1'b0, r_sum}) : w_rem_sh[SUM_W-1:0];
            r_quo <= {r_quo[31:0], w_ge};
        end
        if (i_cmd.mul_en) begin
            r_prod <= 48'(w_wsel) * 48'(r_g);
        end
        if (i_cmd.emit_en) begin
            if (i_cmd.emit_empty) begin
                r_out <= '{neighbour_index: '0, weight: '0, last_of_window: 1'b1,
                           window_empty: 1'b1};
            end else begin
                r_out <= '{neighbour_index: r_idx, weight: r_prod[47:16],
                           last_of_window: i_cmd.emit_last, window_empty: 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.wgt_en && o_sts.need_div) begin
                r_cnt <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.emit_en) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

FILE: rtl/huber_neighbour_weight_engine_top.sv
// top level: configuration registers, controller and datapath
// depends on hnw_pkg, hnw_ctrl, hnw_dp, assert_macros.svh
//
// channel   direction  handshake           payload
// in        input      i_in_valid/o_in_stall   i_in_data (t_in)
// out       output     o_out_valid/i_out_stall o_out_data (t_out)
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// a load request does not stall; an evaluate request holds the input stalled
// each neighbour is read, summed, weighted, multiplied and emitted, with a scan per
// skipped window position and a wait on the 33-step serial divider when the range
// weight needs it; results leave through one output register; a stalled output holds
// the walk; synchronous active-low reset clears control state and the settings
`default_nettype none
`include "assert_macros.svh"
module huber_neighbour_weight_engine_top import hnw_pkg::*; #(
    parameter int RADIUS   = DEF_RADIUS,
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out             o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    localparam logic [1:0] CH_MAX = 2'(CHANNELS);

    logic [1:0]       r_stride, r_chans;
    logic [SUM_W-1:0] r_low, r_high;
    logic [31:0]      r_flat, r_floor;
    logic [8:0]       r_rows, r_cols;
    t_cfg             w_cfg;
    t_cmd             w_cmd;
    t_sts             w_sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= 2'd1;
            r_chans  <= 2'd3;
            r_low    <= '0;
            r_high   <= SUM_W'(195075);
            r_flat   <= '0;
            r_floor  <= '0;
            r_rows   <= 9'(MAX_SIDE);
            r_cols   <= 9'(MAX_SIDE);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_STRIDE:   r_stride <= i_cfg_data[1:0];
                CFG_CHANNELS: r_chans  <= i_cfg_data[1:0];
                CFG_LOW:      r_low    <= i_cfg_data[SUM_W-1:0];
                CFG_HIGH:     r_high   <= i_cfg_data[SUM_W-1:0];
                CFG_FLAT:     r_flat   <= i_cfg_data;
                CFG_FLOOR:    r_floor  <= i_cfg_data;
                CFG_ROWS:     r_rows   <= i_cfg_data[8:0];
                CFG_COLS:     r_cols   <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_cfg.stride  = (r_stride == 2'd0) ? 2'd1 : r_stride;
        w_cfg.chans   = (r_chans == 2'd0) ? 2'd1 : ((r_chans > CH_MAX) ? CH_MAX : r_chans);
        w_cfg.low     = r_low;
        w_cfg.high    = r_high;
        w_cfg.flat    = r_flat;
        w_cfg.floor_w = r_floor;
        w_cfg.rows    = (r_rows == 9'd0) ? 9'd1
                      : ((r_rows > 9'(MAX_SIDE)) ? 9'(MAX_SIDE) : r_rows);
        w_cfg.cols    = (r_cols == 9'd0) ? 9'd1
                      : ((r_cols > 9'(MAX_SIDE)) ? 9'(MAX_SIDE) : r_cols);
    end

    hnw_ctrl #(.RADIUS(RADIUS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_cfg      (w_cfg),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    hnw_dp #(.RADIUS(RADIUS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // no divide in flight while requests are taken
    `HNW_ASSERT_IMP(a_idle_no_div, i_clk, i_rst_n, !o_in_stall, !w_sts.div_busy)
    // an empty window result is final and carries no weight
    `HNW_ASSERT_IMP(a_empty_final, i_clk, i_rst_n, o_out_valid && o_out_data.window_empty,
        o_out_data.last_of_window && o_out_data.weight == '0)
    // a non-final result means its window is still being walked
    `HNW_ASSERT_IMP(a_mid_window_busy, i_clk, i_rst_n,
        o_out_valid && !o_out_data.last_of_window, o_in_stall)
endmodule
`default_nettype wire
